/* hw/rtl/hbe_pkg.sv */
// ----------------------------------------------------------------------------
// hbe_pkg
// Types, constants and step functions for the backbone H-bond energy test.
// ----------------------------------------------------------------------------
package hbe_pkg;

    localparam int COORD_BITS  = 21;
    localparam int POS_W       = 63;
    localparam int AD_W        = COORD_BITS + 1;       // absolute axis difference
    localparam int SQ_W        = 2 * COORD_BITS + 2;   // squared distance
    localparam int RT_W        = COORD_BITS + 1;       // integer square root
    localparam int SR_W        = SQ_W + 2;             // square root remainder
    localparam int Q_W         = 25;                   // reciprocal, 2^24 / d
    localparam int LIM_W       = 32;
    localparam int SUM_W       = Q_W + 2;
    localparam int CPL_W       = 16;
    localparam int PROD_W      = SUM_W + CPL_W + 1;
    localparam int EN_W        = 24;

    localparam int SQRT_STEPS  = RT_W;
    localparam int SQRT_PER    = 2;
    localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;
    localparam int DIV_STEPS   = Q_W;
    localparam int DIV_PER     = 2;
    localparam int DIV_STAGES  = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
    localparam int LANE_LAT    = SQRT_STAGES + DIV_STAGES;

    localparam int NUM_ATOMS   = 8;
    localparam int NUM_PAIRS   = 8;
    localparam int NUM_LANES   = 4;

    // atom slots
    localparam int AT_N1 = 0;
    localparam int AT_C1 = 1;
    localparam int AT_O1 = 2;
    localparam int AT_H1 = 3;
    localparam int AT_N2 = 4;
    localparam int AT_C2 = 5;
    localparam int AT_O2 = 6;
    localparam int AT_H2 = 7;

    // distance slots
    localparam int D_C1N2 = 0;
    localparam int D_C2N1 = 1;
    localparam int D_N1O2 = 2;
    localparam int D_O1N2 = 3;
    localparam int D_H1C2 = 4;
    localparam int D_H1O2 = 5;
    localparam int D_H2C1 = 6;
    localparam int D_H2O1 = 7;

    localparam int PAIR_A [NUM_PAIRS] = '{AT_C1, AT_C2, AT_N1, AT_O1,
                                          AT_H1, AT_H1, AT_H2, AT_H2};
    localparam int PAIR_B [NUM_PAIRS] = '{AT_N2, AT_N1, AT_O2, AT_N2,
                                          AT_C2, AT_O2, AT_C1, AT_O1};

    // reciprocal lanes
    localparam int L_ON = 0;
    localparam int L_CH = 1;
    localparam int L_OH = 2;
    localparam int L_CN = 3;

    localparam int REG_THRESHOLD = 0;
    localparam int REG_MIN_CN    = 1;
    localparam int REG_COUPLING  = 2;
    localparam int ADDR_W        = 4;

    localparam logic signed [EN_W-1:0]  THRESHOLD_RST = -24'sd128;
    localparam logic [CPL_W-1:0]        MIN_CN_RST    = 16'd512;
    localparam logic [CPL_W-1:0]        COUPLING_RST  = 16'd7139;
    localparam logic signed [EN_W-1:0]  EN_MAX        = 24'sh7FFFFF;
    localparam logic signed [EN_W-1:0]  EN_MIN        = -24'sh800000;

    typedef struct packed {
        logic             atoms_present;
        logic [POS_W-1:0] first_n_pos;
        logic [POS_W-1:0] first_c_pos;
        logic [POS_W-1:0] first_o_pos;
        logic [POS_W-1:0] first_h_pos;
        logic [POS_W-1:0] second_n_pos;
        logic [POS_W-1:0] second_c_pos;
        logic [POS_W-1:0] second_o_pos;
        logic [POS_W-1:0] second_h_pos;
    } in_item_t;

    typedef struct packed {
        logic                   bonded;
        logic signed [EN_W-1:0] energy;
        logic                   rejected;
    } out_item_t;

    typedef struct packed {
        logic [SR_W-1:0] rem;
        logic [RT_W-1:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [RT_W:0]   rem;
        logic [Q_W-1:0]  quo;
        logic [RT_W-1:0] dvs;
    } div_st_t;

    function automatic logic [AD_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b,
                                                 input int k);
        logic signed [AD_W-1:0] d;
        d = $signed({a[k*COORD_BITS+COORD_BITS-1], a[k*COORD_BITS +: COORD_BITS]})
          - $signed({b[k*COORD_BITS+COORD_BITS-1], b[k*COORD_BITS +: COORD_BITS]});
        return d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
    endfunction

    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input int i);
        sqrt_st_t        r;
        logic [SR_W-1:0] trial;
        r     = s;
        trial = (SR_W'(s.root) << (i + 1)) + (SR_W'(1) << (2 * i));
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = s.root | (RT_W'(1) << i);
        end
        return r;
    endfunction

    function automatic div_st_t div_step(input div_st_t s, input int i);
        div_st_t       r;
        logic [RT_W:0] t;
        r = s;
        t = {s.rem[RT_W-1:0], (i == DIV_STEPS - 1)};
        if (t >= {1'b0, s.dvs})
        begin
            t        = t - {1'b0, s.dvs};
            r.quo[i] = 1'b1;
        end
        r.rem = t;
        return r;
    endfunction

endpackage

/* hw/rtl/hbe_recip_lane.sv */
// ----------------------------------------------------------------------------
// hbe_recip_lane
// Pipelined floor(sqrt) of a squared distance, then floor(2^24 / distance).
// ----------------------------------------------------------------------------
module hbe_recip_lane (
    input  logic                      clk,
    input  logic                      en,
    input  logic [hbe_pkg::SQ_W-1:0]  sq,
    output logic [hbe_pkg::Q_W-1:0]   recip
);

    hbe_pkg::sqrt_st_t sq_st_reg   [hbe_pkg::SQRT_STAGES];
    hbe_pkg::sqrt_st_t sq_st_next  [hbe_pkg::SQRT_STAGES];
    hbe_pkg::div_st_t  dv_st_reg   [hbe_pkg::DIV_STAGES];
    hbe_pkg::div_st_t  dv_st_next  [hbe_pkg::DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < hbe_pkg::SQRT_STAGES; g++)
        begin : g_sqrt
            always_comb
            begin
                hbe_pkg::sqrt_st_t s;
                if (g == 0)
                begin
                    s.rem  = hbe_pkg::SR_W'(sq);
                    s.root = '0;
                end
                else
                begin
                    s = sq_st_reg[(g == 0) ? 0 : g - 1];
                end
                for (int j = 0; j < hbe_pkg::SQRT_PER; j++)
                begin
                    if (g * hbe_pkg::SQRT_PER + j < hbe_pkg::SQRT_STEPS)
                    begin
                        s = hbe_pkg::sqrt_step(s,
                            hbe_pkg::SQRT_STEPS - 1 - (g * hbe_pkg::SQRT_PER + j));
                    end
                end
                sq_st_next[g] = s;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_st_reg[g] <= sq_st_next[g];
                end
            end
        end

        for (g = 0; g < hbe_pkg::DIV_STAGES; g++)
        begin : g_div
            always_comb
            begin
                hbe_pkg::div_st_t s;
                if (g == 0)
                begin
                    s.rem = '0;
                    s.quo = '0;
                    s.dvs = sq_st_reg[hbe_pkg::SQRT_STAGES-1].root;
                end
                else
                begin
                    s = dv_st_reg[(g == 0) ? 0 : g - 1];
                end
                for (int j = 0; j < hbe_pkg::DIV_PER; j++)
                begin
                    if (g * hbe_pkg::DIV_PER + j < hbe_pkg::DIV_STEPS)
                    begin
                        s = hbe_pkg::div_step(s,
                            hbe_pkg::DIV_STEPS - 1 - (g * hbe_pkg::DIV_PER + j));
                    end
                end
                dv_st_next[g] = s;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_st_reg[g] <= dv_st_next[g];
                end
            end
        end
    endgenerate

    assign recip = dv_st_reg[hbe_pkg::DIV_STAGES-1].quo;

endmodule

/* hw/rtl/backbone_hbond_energy_test_top.sv */
// ----------------------------------------------------------------------------
// backbone_hbond_energy_test_top
// DSSP backbone hydrogen-bond energy test, one residue pair per item.
// ----------------------------------------------------------------------------
// One item enters per cycle and its result passes through four distance
// stages, 24 stages of square root and reciprocal in each of four lanes,
// sum, multiply and output register. The whole pipe holds while the
// output item is stalled; otherwise an item is taken every clock.
module backbone_hbond_energy_test_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  hbe_pkg::in_item_t             req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output hbe_pkg::out_item_t            rsp_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbe_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic signed [hbe_pkg::EN_W-1:0]  threshold_reg;
    logic [hbe_pkg::CPL_W-1:0]        min_cn_reg;
    logic [hbe_pkg::CPL_W-1:0]        coupling_reg;
    logic                             wr_en;
    logic [1:0]                       wr_idx;

    logic                             en;
    logic [hbe_pkg::POS_W-1:0]        pos [hbe_pkg::NUM_ATOMS];

    logic                             s1_valid_reg;
    logic                             s1_atoms_reg;
    logic [hbe_pkg::AD_W-1:0]         s1_ad_reg [hbe_pkg::NUM_PAIRS][3];
    logic                             s2_valid_reg;
    logic                             s2_atoms_reg;
    logic [2*hbe_pkg::AD_W-1:0]       s2_sqr_reg [hbe_pkg::NUM_PAIRS][3];
    logic                             s3_valid_reg;
    logic                             s3_atoms_reg;
    logic [hbe_pkg::SQ_W-1:0]         s3_sum_reg [hbe_pkg::NUM_PAIRS];
    logic                             s4_valid_reg;
    logic                             s4_rej_reg;
    logic                             s4_zero_reg;
    logic [hbe_pkg::SQ_W-1:0]         s4_sq_reg [hbe_pkg::NUM_LANES];
    logic                             s4_rej_next;
    logic                             s4_zero_next;
    logic [hbe_pkg::SQ_W-1:0]         s4_sq_next [hbe_pkg::NUM_LANES];
    logic [hbe_pkg::LIM_W-1:0]        lim;

    logic                             ln_valid_reg [hbe_pkg::LANE_LAT];
    logic                             ln_rej_reg   [hbe_pkg::LANE_LAT];
    logic                             ln_zero_reg  [hbe_pkg::LANE_LAT];
    logic [hbe_pkg::Q_W-1:0]          recip [hbe_pkg::NUM_LANES];

    logic                             s5_valid_reg;
    logic                             s5_rej_reg;
    logic                             s5_zero_reg;
    logic signed [hbe_pkg::SUM_W-1:0] s5_sum_reg;
    logic                             s6_valid_reg;
    logic                             s6_rej_reg;
    logic                             s6_zero_reg;
    logic signed [hbe_pkg::PROD_W-1:0] s6_prod_reg;

    logic signed [hbe_pkg::PROD_W-1:0] rounded;
    logic signed [hbe_pkg::PROD_W-17:0] shifted;
    logic signed [hbe_pkg::EN_W-1:0]  energy_next;
    logic                             out_valid_reg;
    hbe_pkg::out_item_t               out_item_reg;
    hbe_pkg::out_item_t               out_item_next;

    // configuration
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= hbe_pkg::THRESHOLD_RST;
            min_cn_reg    <= hbe_pkg::MIN_CN_RST;
            coupling_reg  <= hbe_pkg::COUPLING_RST;
        end
        else if (wr_en)
        begin
            case (32'(wr_idx))
                hbe_pkg::REG_THRESHOLD: threshold_reg <= pwdata[hbe_pkg::EN_W-1:0];
                hbe_pkg::REG_MIN_CN:    min_cn_reg    <= pwdata[hbe_pkg::CPL_W-1:0];
                hbe_pkg::REG_COUPLING:  coupling_reg  <= pwdata[hbe_pkg::CPL_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (32'(wr_idx))
            hbe_pkg::REG_THRESHOLD: prdata = 32'(threshold_reg);
            hbe_pkg::REG_MIN_CN:    prdata = 32'(min_cn_reg);
            hbe_pkg::REG_COUPLING:  prdata = 32'(coupling_reg);
            default:                prdata = '0;
        endcase
    end

    // flow control: the pipe advances unless the output item is held
    assign en        = !(out_valid_reg && rsp_stall);
    assign req_stall = !en;

    assign pos[hbe_pkg::AT_N1] = req_item.first_n_pos;
    assign pos[hbe_pkg::AT_C1] = req_item.first_c_pos;
    assign pos[hbe_pkg::AT_O1] = req_item.first_o_pos;
    assign pos[hbe_pkg::AT_H1] = req_item.first_h_pos;
    assign pos[hbe_pkg::AT_N2] = req_item.second_n_pos;
    assign pos[hbe_pkg::AT_C2] = req_item.second_c_pos;
    assign pos[hbe_pkg::AT_O2] = req_item.second_o_pos;
    assign pos[hbe_pkg::AT_H2] = req_item.second_h_pos;

    assign lim = min_cn_reg * min_cn_reg;

    always_comb
    begin
        logic donor_one;
        s4_rej_next = !s3_atoms_reg
            || (s3_sum_reg[hbe_pkg::D_C1N2] < hbe_pkg::SQ_W'(lim))
            || (s3_sum_reg[hbe_pkg::D_C2N1] < hbe_pkg::SQ_W'(lim));
        donor_one = s3_sum_reg[hbe_pkg::D_N1O2] < s3_sum_reg[hbe_pkg::D_O1N2];
        if (donor_one)
        begin
            s4_sq_next[hbe_pkg::L_ON] = s3_sum_reg[hbe_pkg::D_N1O2];
            s4_sq_next[hbe_pkg::L_CH] = s3_sum_reg[hbe_pkg::D_H1C2];
            s4_sq_next[hbe_pkg::L_OH] = s3_sum_reg[hbe_pkg::D_H1O2];
            s4_sq_next[hbe_pkg::L_CN] = s3_sum_reg[hbe_pkg::D_C2N1];
        end
        else
        begin
            s4_sq_next[hbe_pkg::L_ON] = s3_sum_reg[hbe_pkg::D_O1N2];
            s4_sq_next[hbe_pkg::L_CH] = s3_sum_reg[hbe_pkg::D_H2C1];
            s4_sq_next[hbe_pkg::L_OH] = s3_sum_reg[hbe_pkg::D_H2O1];
            s4_sq_next[hbe_pkg::L_CN] = s3_sum_reg[hbe_pkg::D_C1N2];
        end
        s4_zero_next = 1'b0;
        for (int l = 0; l < hbe_pkg::NUM_LANES; l++)
        begin
            if (s4_sq_next[l] == '0)
            begin
                s4_zero_next = 1'b1;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < hbe_pkg::LANE_LAT; k++)
            begin
                ln_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg    <= req_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            ln_valid_reg[0] <= s4_valid_reg;
            for (int k = 1; k < hbe_pkg::LANE_LAT; k++)
            begin
                ln_valid_reg[k] <= ln_valid_reg[k-1];
            end
            s5_valid_reg  <= ln_valid_reg[hbe_pkg::LANE_LAT-1];
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_atoms_reg <= req_item.atoms_present;
            for (int p = 0; p < hbe_pkg::NUM_PAIRS; p++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s1_ad_reg[p][k]  <= hbe_pkg::abs_diff(pos[hbe_pkg::PAIR_A[p]],
                                                          pos[hbe_pkg::PAIR_B[p]], k);
                    s2_sqr_reg[p][k] <= s1_ad_reg[p][k] * s1_ad_reg[p][k];
                end
                s3_sum_reg[p] <= hbe_pkg::SQ_W'(s2_sqr_reg[p][0])
                               + hbe_pkg::SQ_W'(s2_sqr_reg[p][1])
                               + hbe_pkg::SQ_W'(s2_sqr_reg[p][2]);
            end
            s2_atoms_reg <= s1_atoms_reg;
            s3_atoms_reg <= s2_atoms_reg;
            s4_rej_reg   <= s4_rej_next;
            s4_zero_reg  <= s4_zero_next;
            for (int l = 0; l < hbe_pkg::NUM_LANES; l++)
            begin
                s4_sq_reg[l] <= s4_sq_next[l];
            end
            ln_rej_reg[0]  <= s4_rej_reg;
            ln_zero_reg[0] <= s4_zero_reg;
            for (int k = 1; k < hbe_pkg::LANE_LAT; k++)
            begin
                ln_rej_reg[k]  <= ln_rej_reg[k-1];
                ln_zero_reg[k] <= ln_zero_reg[k-1];
            end
            s5_rej_reg  <= ln_rej_reg[hbe_pkg::LANE_LAT-1];
            s5_zero_reg <= ln_zero_reg[hbe_pkg::LANE_LAT-1];
            s5_sum_reg  <= $signed(hbe_pkg::SUM_W'(recip[hbe_pkg::L_ON]))
                         + $signed(hbe_pkg::SUM_W'(recip[hbe_pkg::L_CH]))
                         - $signed(hbe_pkg::SUM_W'(recip[hbe_pkg::L_OH]))
                         - $signed(hbe_pkg::SUM_W'(recip[hbe_pkg::L_CN]));
            s6_rej_reg  <= s5_rej_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_prod_reg <= s5_sum_reg * $signed({1'b0, coupling_reg});
            out_item_reg <= out_item_next;
        end
    end

    genvar gl;
    generate
        for (gl = 0; gl < hbe_pkg::NUM_LANES; gl++)
        begin : g_lane
            hbe_recip_lane u_lane (
                .clk   (clk),
                .en    (en),
                .sq    (s4_sq_reg[gl]),
                .recip (recip[gl])
            );
        end
    endgenerate

    // round, saturate, compare
    assign rounded = s6_prod_reg + hbe_pkg::PROD_W'(32768);
    assign shifted = rounded[hbe_pkg::PROD_W-1:16];

    always_comb
    begin
        if (s6_rej_reg || s6_zero_reg)
        begin
            energy_next = '0;
        end
        else if (shifted > $signed((hbe_pkg::PROD_W-16)'(hbe_pkg::EN_MAX)))
        begin
            energy_next = hbe_pkg::EN_MAX;
        end
        else if (shifted < $signed((hbe_pkg::PROD_W-16)'(hbe_pkg::EN_MIN)))
        begin
            energy_next = hbe_pkg::EN_MIN;
        end
        else
        begin
            energy_next = shifted[hbe_pkg::EN_W-1:0];
        end
        out_item_next.energy   = energy_next;
        out_item_next.rejected = s6_rej_reg;
        out_item_next.bonded   = !s6_rej_reg && (energy_next < threshold_reg);
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.rejected |-> rsp_item.energy == '0 && !rsp_item.bonded)
        else $error("rejected item carries energy or bond");

    a_bond_thr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.bonded |-> rsp_item.energy < threshold_reg)
        else $error("bond flagged at or above threshold");

    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("input taken while output held");

endmodule

/* tb/tb_backbone_hbond_energy_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backbone_hbond_energy_test_top
// Drives residue pairs into the H-bond energy test, predicts energy, bonded
// and rejected flags for each item, and checks every result in order while
// both sides stall at random and the registers move between phases.
// ----------------------------------------------------------------------------
module tb_backbone_hbond_energy_test_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    hbe_pkg::in_item_t          req_item;
    logic                       rsp_valid;
    logic                       rsp_stall;
    hbe_pkg::out_item_t         rsp_item;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hbe_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    hbe_pkg::in_item_t   pending_pairs[$];
    hbe_pkg::out_item_t  expected_bonds[$];
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic signed [23:0]  threshold_reg;
    logic [15:0]         min_cn_reg;
    logic [15:0]         coupling_reg;

    backbone_hbond_energy_test_top uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic signed [63:0] coord(input logic [62:0] w, input int k);
        logic [20:0] c;
        c = w[k*21 +: 21];
        return {{43{c[20]}}, c};
    endfunction

    function automatic logic [63:0] sq_dist(input logic [62:0] a, input logic [62:0] b);
        logic [63:0]        s;
        logic signed [63:0] d;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = coord(a, k) - coord(b, k);
            s += d * d;
        end
        return s;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        return r;
    endfunction

    function automatic logic signed [63:0] inv_dist(input logic [63:0] sq);
        logic [63:0] d;
        d = int_root(sq);
        return (64'd1 << 24) / d;
    endfunction

    function automatic hbe_pkg::out_item_t bond_energy(input hbe_pkg::in_item_t p);
        hbe_pkg::out_item_t r;
        logic [63:0]        lim, on, ch, oh, cn;
        logic signed [63:0] s, e;
        r = '0;
        lim = min_cn_reg * min_cn_reg;
        r.rejected = !p.atoms_present || sq_dist(p.first_c_pos, p.second_n_pos) < lim
                     || sq_dist(p.second_c_pos, p.first_n_pos) < lim;
        e = 0;
        if (!r.rejected)
        begin
            if (sq_dist(p.first_n_pos, p.second_o_pos) < sq_dist(p.first_o_pos, p.second_n_pos))
            begin
                on = sq_dist(p.first_n_pos, p.second_o_pos);
                ch = sq_dist(p.first_h_pos, p.second_c_pos);
                oh = sq_dist(p.first_h_pos, p.second_o_pos);
                cn = sq_dist(p.first_n_pos, p.second_c_pos);
            end
            else
            begin
                on = sq_dist(p.second_n_pos, p.first_o_pos);
                ch = sq_dist(p.second_h_pos, p.first_c_pos);
                oh = sq_dist(p.second_h_pos, p.first_o_pos);
                cn = sq_dist(p.second_n_pos, p.first_c_pos);
            end
            if (on != 0 && ch != 0 && oh != 0 && cn != 0)
            begin
                s = inv_dist(on) + inv_dist(ch) - inv_dist(oh) - inv_dist(cn);
                e = (s * $signed({48'd0, coupling_reg}) + 32768) >>> 16;
                if (e > 64'sd8388607)
                    e = 64'sd8388607;
                if (e < -64'sd8388608)
                    e = -64'sd8388608;
            end
            r.bonded = $signed(e) < $signed(threshold_reg);
        end
        r.energy = e[23:0];
        return r;
    endfunction

    task automatic write_reg(input int idx, input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hbe_pkg::ADDR_W'(4 * idx);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hbe_pkg::REG_THRESHOLD: threshold_reg = v[23:0];
            hbe_pkg::REG_MIN_CN:    min_cn_reg    = v[15:0];
            hbe_pkg::REG_COUPLING:  coupling_reg  = v[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [62:0] pack_pos(input int x, input int y, input int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic logic [62:0] near_pos(input logic [62:0] base, input int span);
        return pack_pos($signed(base[20:0]) + $urandom_range(2 * span) - span,
                        $signed(base[41:21]) + $urandom_range(2 * span) - span,
                        $signed(base[62:42]) + $urandom_range(2 * span) - span);
    endfunction

    function automatic logic [62:0] any_pos();
        return 63'({$urandom, $urandom});
    endfunction

    // realistic geometry: two residues a few Angstrom apart
    function automatic hbe_pkg::in_item_t real_pair(input int span);
        hbe_pkg::in_item_t p;
        logic [62:0]       c;
        c = pack_pos($urandom_range(200000) - 100000, $urandom_range(200000) - 100000,
                     $urandom_range(200000) - 100000);
        p.atoms_present = ($urandom_range(19) != 0);
        p.first_n_pos   = near_pos(c, span);
        p.first_c_pos   = near_pos(c, span);
        p.first_o_pos   = near_pos(c, span);
        p.first_h_pos   = near_pos(p.first_n_pos, 300);
        p.second_n_pos  = near_pos(c, span);
        p.second_c_pos  = near_pos(c, span);
        p.second_o_pos  = near_pos(c, span);
        p.second_h_pos  = near_pos(p.second_n_pos, 300);
        return p;
    endfunction

    function automatic hbe_pkg::in_item_t rand_pair();
        hbe_pkg::in_item_t p;
        int                sel;
        sel = $urandom_range(9);
        if (sel < 6)
            p = real_pair(1500);
        else if (sel < 8)
            p = real_pair(40);
        else
        begin
            p.atoms_present = 1'($urandom_range(1));
            p.first_n_pos   = any_pos();
            p.first_c_pos   = any_pos();
            p.first_o_pos   = any_pos();
            p.first_h_pos   = any_pos();
            p.second_n_pos  = any_pos();
            p.second_c_pos  = any_pos();
            p.second_o_pos  = any_pos();
            p.second_h_pos  = any_pos();
        end
        return p;
    endfunction

    task automatic run_phase(input int count, input int s_pct, input int r_pct);
        hbe_pkg::in_item_t p;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            p = rand_pair();
            pending_pairs = {pending_pairs, p};
        end
        wait (pending_pairs.size() == 0 && expected_bonds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item  <= '0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
            if (req_valid && !req_stall)
            begin
                expected_bonds = {expected_bonds, bond_energy(req_item)};
                void'(pending_pairs.pop_front());
            end
            if (!(req_valid && req_stall))
            begin
                if (pending_pairs.size() > (req_valid && !req_stall ? 0 : 0)
                    && ($urandom_range(99) >= send_idle_pct) && pending_pairs.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_item  <= pending_pairs[0];
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_bonds.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result %p", rsp_item);
                end
                else
                begin
                    if (rsp_item !== expected_bonds[0])
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected %p actual %p",
                                     expected_bonds[0], rsp_item);
                    end
                    void'(expected_bonds.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        hbe_pkg::in_item_t p;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        threshold_reg  = hbe_pkg::THRESHOLD_RST;
        min_cn_reg     = hbe_pkg::MIN_CN_RST;
        coupling_reg   = hbe_pkg::COUPLING_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: absent atoms, all zero, extremes, coincident atoms, donor sides
        p = '0;
        pending_pairs = {pending_pairs, p};
        p.atoms_present = 1'b1;
        pending_pairs = {pending_pairs, p};
        p = '1;
        pending_pairs = {pending_pairs, p};
        p = {1'b1, {8{pack_pos(-1048576, -1048576, -1048576)}}};
        p.second_n_pos = pack_pos(1048575, 1048575, 1048575);
        p.second_c_pos = p.second_n_pos;
        pending_pairs = {pending_pairs, p};
        p.first_o_pos = pack_pos(1048575, 1048575, -1048576);
        p.first_h_pos = pack_pos(-1048576, 1048575, 1048575);
        pending_pairs = {pending_pairs, p};
        // residue one donor, typical helix geometry
        p.atoms_present = 1'b1;
        p.first_n_pos  = pack_pos(0, 0, 0);
        p.first_h_pos  = pack_pos(256, 0, 0);
        p.first_c_pos  = pack_pos(-300, 300, 0);
        p.first_o_pos  = pack_pos(-300, 600, 0);
        p.second_o_pos = pack_pos(750, 0, 0);
        p.second_c_pos = pack_pos(1050, 0, 0);
        p.second_n_pos = pack_pos(1400, 400, 0);
        p.second_h_pos = pack_pos(1600, 400, 0);
        pending_pairs = {pending_pairs, p};
        // mirrored: residue two donates
        p = {p.atoms_present, p.second_n_pos, p.second_c_pos, p.second_o_pos,
             p.second_h_pos, p.first_n_pos, p.first_c_pos, p.first_o_pos,
             p.first_h_pos};
        pending_pairs = {pending_pairs, p};
        // zero distance from residue one's H to residue two's O, a pair unused while residue two donates
        p.first_h_pos = p.second_o_pos;
        pending_pairs = {pending_pairs, p};
        // C-N just at and under the minimum
        p = real_pair(1500);
        p.atoms_present = 1'b1;
        p.first_c_pos  = pack_pos(0, 0, 0);
        p.second_n_pos = pack_pos(512, 0, 0);
        pending_pairs = {pending_pairs, p};
        p.second_n_pos = pack_pos(511, 0, 0);
        pending_pairs = {pending_pairs, p};
        for (int i = 0; i < 10; i++)
        begin
            p = real_pair(300);
            pending_pairs = {pending_pairs, p};
        end
        wait (pending_pairs.size() == 0 && expected_bonds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        run_phase(250, 6, 61);
        write_reg(hbe_pkg::REG_THRESHOLD, 32'h0080_0000);
        write_reg(hbe_pkg::REG_MIN_CN, 32'd0);
        write_reg(hbe_pkg::REG_COUPLING, 32'hFFFF);
        run_phase(250, 61, 6);
        write_reg(hbe_pkg::REG_THRESHOLD, 32'h007F_FFFF);
        write_reg(hbe_pkg::REG_MIN_CN, 32'hFFFF);
        write_reg(hbe_pkg::REG_COUPLING, 32'd0);
        run_phase(150, 0, 0);
        write_reg(hbe_pkg::REG_THRESHOLD, 32'd0);
        write_reg(hbe_pkg::REG_MIN_CN, 32'd200);
        write_reg(hbe_pkg::REG_COUPLING, 32'd7139);
        run_phase(300, 6, 61);
        write_reg(hbe_pkg::REG_THRESHOLD, {8'd0, 24'($urandom_range(400) - 200)});
        write_reg(hbe_pkg::REG_MIN_CN, 32'd1);
        write_reg(hbe_pkg::REG_COUPLING, 32'($urandom_range(65535)));
        run_phase(330, 0, 0);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* backbone_hbond_energy_test_top.f */
hw/rtl/hbe_pkg.sv
hw/rtl/hbe_recip_lane.sv
hw/rtl/backbone_hbond_energy_test_top.sv
tb/tb_backbone_hbond_energy_test_top.sv
